// File: src/cst_pkg.sv
// Shared types, character codes, token codes and keyword table of the tokenizer.
// Depends on nothing; every other file of the block imports it.
package cst_pkg;

   localparam int MAX_TEXT          = 65536;
   localparam int KEYWORD_BYTES_DEF = 5;
   localparam int POS_W             = 16;
   localparam int LEN_W             = 16;
   localparam int SLOTS             = 5;
   localparam int MAX_RES           = 4;
   localparam int Q_DEPTH           = 8;

   localparam logic [POS_W-1:0] POS_LIMIT =
      (MAX_TEXT - 1 > 65535) ? {POS_W{1'b1}} : POS_W'(MAX_TEXT - 1);

   localparam logic [1:0] MODE_DEFAULT = 2'd0;
   localparam logic [1:0] MODE_STRING  = 2'd1;
   localparam logic [1:0] MODE_LINE    = 2'd2;
   localparam logic [1:0] MODE_BLOCK   = 2'd3;

   localparam logic [5:0] T_NUMBER        = 6'd0;
   localparam logic [5:0] T_STRING        = 6'd1;
   localparam logic [5:0] T_LPAREN        = 6'd2;
   localparam logic [5:0] T_RPAREN        = 6'd3;
   localparam logic [5:0] T_PLUS          = 6'd4;
   localparam logic [5:0] T_MINUS         = 6'd5;
   localparam logic [5:0] T_MULT          = 6'd6;
   localparam logic [5:0] T_DIV           = 6'd7;
   localparam logic [5:0] T_MOD           = 6'd8;
   localparam logic [5:0] T_IDENTIFIER    = 6'd9;
   localparam logic [5:0] T_COMMA         = 6'd10;
   localparam logic [5:0] T_ASSIGN        = 6'd11;
   localparam logic [5:0] T_COLON         = 6'd12;
   localparam logic [5:0] T_SEMICOLON     = 6'd13;
   localparam logic [5:0] T_LBRACE        = 6'd14;
   localparam logic [5:0] T_RBRACE        = 6'd15;
   localparam logic [5:0] T_LBRACK        = 6'd16;
   localparam logic [5:0] T_RBRACK        = 6'd17;
   localparam logic [5:0] T_LT            = 6'd18;
   localparam logic [5:0] T_GT            = 6'd19;
   localparam logic [5:0] T_DOT           = 6'd20;
   localparam logic [5:0] T_NOT           = 6'd21;
   localparam logic [5:0] T_COMMENT_LINE  = 6'd22;
   localparam logic [5:0] T_COMMENT_BLOCK = 6'd23;
   localparam logic [5:0] T_PLUS_ASSIGN   = 6'd24;
   localparam logic [5:0] T_MINUS_ASSIGN  = 6'd25;
   localparam logic [5:0] T_MULT_ASSIGN   = 6'd26;
   localparam logic [5:0] T_DIV_ASSIGN    = 6'd27;
   localparam logic [5:0] T_MOD_ASSIGN    = 6'd28;
   localparam logic [5:0] T_EQUAL         = 6'd29;
   localparam logic [5:0] T_NOT_EQUAL     = 6'd30;
   localparam logic [5:0] T_LT_EQUAL      = 6'd31;
   localparam logic [5:0] T_GT_EQUAL      = 6'd32;
   localparam logic [5:0] T_AND           = 6'd33;
   localparam logic [5:0] T_OR            = 6'd34;
   localparam logic [5:0] T_INC           = 6'd35;
   localparam logic [5:0] T_DEC           = 6'd36;
   localparam logic [5:0] T_DO            = 6'd37;
   localparam logic [5:0] T_TIMES         = 6'd38;
   localparam logic [5:0] T_WHILE         = 6'd39;
   localparam logic [5:0] T_IF            = 6'd40;
   localparam logic [5:0] T_ELSE          = 6'd41;
   localparam logic [5:0] T_VAR           = 6'd42;
   localparam logic [5:0] T_BITWISE_AND   = 6'd43;
   localparam logic [5:0] T_BITWISE_OR    = 6'd44;
   localparam logic [5:0] T_NEW_LINE      = 6'd45;

   localparam logic [7:0] CH_HT     = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SP     = 8'h20;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_LPAR   = 8'h28;
   localparam logic [7:0] CH_RPAR   = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_LBRK   = 8'h5B;
   localparam logic [7:0] CH_BSL    = 8'h5C;
   localparam logic [7:0] CH_RBRK   = 8'h5D;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_LBRC   = 8'h7B;
   localparam logic [7:0] CH_BAR    = 8'h7C;
   localparam logic [7:0] CH_RBRC   = 8'h7D;

   localparam logic [2:0] CLS_WORD  = 3'd0;
   localparam logic [2:0] CLS_SPACE = 3'd1;
   localparam logic [2:0] CLS_OP    = 3'd2;
   localparam logic [2:0] CLS_SLASH = 3'd3;
   localparam logic [2:0] CLS_QUOTE = 3'd4;
   localparam logic [2:0] CLS_BSL   = 3'd5;

   localparam int KW_NUM = 6;
   localparam int KW_W   = 40;
   localparam logic [KW_NUM-1:0][KW_W-1:0] KW_TEXT = {
      40'h0000726176, 40'h0065736c65, 40'h0000006669,
      40'h656c696877, 40'h73656d6974, 40'h0000006f64};
   localparam logic [KW_NUM-1:0][2:0] KW_LEN = {3'd3, 3'd4, 3'd2, 3'd5, 3'd5, 3'd2};
   localparam logic [KW_NUM-1:0][5:0] KW_CODE = {T_VAR, T_ELSE, T_IF, T_WHILE, T_TIMES, T_DO};

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [5:0]       token_code;
      logic [POS_W-1:0] token_start;
      logic [LEN_W-1:0] token_length;
      logic             last_in_run;
   } rsp_type;

   typedef struct packed {
      logic             vld;
      logic [5:0]       code;
      logic [POS_W-1:0] start;
      logic [LEN_W-1:0] len;
   } tok_type;

   typedef struct packed {
      logic [1:0]       mode;
      logic             quote_dbl;
      logic [POS_W-1:0] wstart;
      logic [LEN_W-1:0] wlen;
      logic             digit_first;
   } lex_state_type;

   typedef struct packed {
      logic [5:0] code;
      logic       pair;
   } op_type;

   function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] p);
      return (p >= POS_LIMIT) ? POS_LIMIT : p + 1'b1;
   endfunction

   function automatic logic [LEN_W-1:0] len_add(input logic [LEN_W-1:0] l,
                                                input logic [1:0] d);
      logic [LEN_W:0] s;
      s = {1'b0, l} + {{(LEN_W-1){1'b0}}, d};
      return s[LEN_W] ? {LEN_W{1'b1}} : s[LEN_W-1:0];
   endfunction

   function automatic logic [2:0] char_class(input logic [7:0] c);
      logic [2:0] r;
      unique case (c) inside
         CH_SP, [CH_HT:CH_CR]:           r = CLS_SPACE;
         CH_SLASH:                       r = CLS_SLASH;
         CH_DQUOTE, CH_SQUOTE:           r = CLS_QUOTE;
         CH_BSL:                         r = CLS_BSL;
         CH_PLUS, CH_MINUS, CH_STAR, CH_PCT, CH_EQ, CH_LT, CH_GT, CH_BANG,
         CH_AMP, CH_BAR, CH_LPAR, CH_RPAR, CH_LBRK, CH_RBRK, CH_LBRC,
         CH_RBRC, CH_DOT, CH_COMMA, CH_COLON, CH_SEMI: r = CLS_OP;
         default:                        r = CLS_WORD;
      endcase
      return r;
   endfunction

   function automatic op_type op_decode(input logic [7:0] c, input logic hp,
                                        input logic [7:0] pk);
      op_type r;
      logic   eq;
      eq = hp && (pk == CH_EQ);
      r  = op_type'{T_IDENTIFIER, 1'b0};
      unique case (c)
         CH_PLUS:  r = eq ? op_type'{T_PLUS_ASSIGN, 1'b1} :
                       (hp && pk == CH_PLUS) ? op_type'{T_INC, 1'b1} :
                       op_type'{T_PLUS, 1'b0};
         CH_MINUS: r = eq ? op_type'{T_MINUS_ASSIGN, 1'b1} :
                       (hp && pk == CH_MINUS) ? op_type'{T_DEC, 1'b1} :
                       op_type'{T_MINUS, 1'b0};
         CH_STAR:  r = eq ? op_type'{T_MULT_ASSIGN, 1'b1} : op_type'{T_MULT, 1'b0};
         CH_PCT:   r = eq ? op_type'{T_MOD_ASSIGN, 1'b1} : op_type'{T_MOD, 1'b0};
         CH_EQ:    r = eq ? op_type'{T_EQUAL, 1'b1} : op_type'{T_ASSIGN, 1'b0};
         CH_LT:    r = eq ? op_type'{T_LT_EQUAL, 1'b1} : op_type'{T_LT, 1'b0};
         CH_GT:    r = eq ? op_type'{T_GT_EQUAL, 1'b1} : op_type'{T_GT, 1'b0};
         CH_BANG:  r = eq ? op_type'{T_NOT_EQUAL, 1'b1} : op_type'{T_NOT, 1'b0};
         CH_AMP:   r = (hp && pk == CH_AMP) ? op_type'{T_AND, 1'b1} :
                       op_type'{T_BITWISE_AND, 1'b0};
         CH_BAR:   r = (hp && pk == CH_BAR) ? op_type'{T_OR, 1'b1} :
                       op_type'{T_BITWISE_OR, 1'b0};
         CH_LPAR:  r = op_type'{T_LPAREN, 1'b0};
         CH_RPAR:  r = op_type'{T_RPAREN, 1'b0};
         CH_LBRK:  r = op_type'{T_LBRACK, 1'b0};
         CH_RBRK:  r = op_type'{T_RBRACK, 1'b0};
         CH_LBRC:  r = op_type'{T_LBRACE, 1'b0};
         CH_RBRC:  r = op_type'{T_RBRACE, 1'b0};
         CH_DOT:   r = op_type'{T_DOT, 1'b0};
         CH_COMMA: r = op_type'{T_COMMA, 1'b0};
         CH_COLON: r = op_type'{T_COLON, 1'b0};
         CH_SEMI:  r = op_type'{T_SEMICOLON, 1'b0};
         default:  r = op_type'{T_IDENTIFIER, 1'b0};
      endcase
      return r;
   endfunction

endpackage

// File: src/cst_kw.sv
// Word classifier: keyword compare on length and leading-byte window, else number/identifier.
// Depends on cst_pkg.
module cst_kw import cst_pkg::*; #(
   parameter int KEYWORD_BYTES = KEYWORD_BYTES_DEF
) (
   input  logic [LEN_W-1:0]           wlen,
   input  logic [8*KEYWORD_BYTES-1:0] win,
   input  logic                       digit_first,
   output logic [5:0]                 code
);

   localparam int WIN_W = 8 * KEYWORD_BYTES;

   always_comb begin
      code = digit_first ? T_NUMBER : T_IDENTIFIER;
      for (int k = 0; k < KW_NUM; k++) begin
         if (wlen == LEN_W'(KW_LEN[k]) && win == WIN_W'(KW_TEXT[k])) begin
            code = KW_CODE[k];
         end
      end
   end

endmodule

// File: src/cst_lex.sv
// One lexing step on a single byte with optional lookahead: mode logic, operators, words.
// Depends on cst_pkg and cst_kw.
module cst_lex import cst_pkg::*; #(
   parameter int KEYWORD_BYTES = KEYWORD_BYTES_DEF
) (
   input  lex_state_type              st_i,
   input  logic [8*KEYWORD_BYTES-1:0] win_i,
   input  logic [7:0]                 c,
   input  logic                       hp,
   input  logic [7:0]                 pk,
   input  logic [POS_W-1:0]           pos,
   output lex_state_type              st_o,
   output logic [8*KEYWORD_BYTES-1:0] win_o,
   output tok_type                    tok0,
   output tok_type                    tok1,
   output logic                       used
);

   localparam int WIN_W = 8 * KEYWORD_BYTES;

   logic [5:0]       kw_code;
   logic [2:0]       cls;
   op_type           op;
   tok_type          flush_tok;
   logic [7:0]       quote_ch;
   logic [WIN_W-1:0] win_base;

   function automatic lex_state_type clear_word(input lex_state_type s);
      lex_state_type r;
      r             = s;
      r.wstart      = '0;
      r.wlen        = '0;
      r.digit_first = 1'b0;
      return r;
   endfunction

   cst_kw #(.KEYWORD_BYTES(KEYWORD_BYTES)) u_kw (
      .wlen        (st_i.wlen),
      .win         (win_i),
      .digit_first (st_i.digit_first),
      .code        (kw_code)
   );

   assign cls       = char_class(c);
   assign op        = op_decode(c, hp, pk);
   assign quote_ch  = st_i.quote_dbl ? CH_DQUOTE : CH_SQUOTE;
   assign flush_tok = '{st_i.wlen != '0, kw_code, st_i.wstart, st_i.wlen};

   always_comb begin
      st_o     = st_i;
      win_o    = win_i;
      win_base = win_i;
      tok0     = '0;
      tok1     = '0;
      used     = 1'b0;
      unique case (st_i.mode)
         MODE_STRING: begin
            st_o.wlen = len_add(st_i.wlen, 2'd1);
            if (c == quote_ch) begin
               tok0      = '{1'b1, T_STRING, st_i.wstart, len_add(st_i.wlen, 2'd1)};
               st_o      = clear_word(st_i);
               st_o.mode = MODE_DEFAULT;
               win_o     = '0;
            end
         end
         MODE_LINE: begin
            if (c == CH_BSL && hp && pk == CH_N) begin
               tok0      = '{1'b1, T_COMMENT_LINE, st_i.wstart, st_i.wlen};
               tok1      = '{1'b1, T_NEW_LINE, pos, LEN_W'(2)};
               st_o      = clear_word(st_i);
               st_o.mode = MODE_DEFAULT;
               win_o     = '0;
               used      = 1'b1;
            end else begin
               st_o.wlen = len_add(st_i.wlen, 2'd1);
            end
         end
         MODE_BLOCK: begin
            if (c == CH_STAR && hp && pk == CH_SLASH) begin
               tok0      = '{1'b1, T_COMMENT_BLOCK, st_i.wstart, len_add(st_i.wlen, 2'd2)};
               st_o      = clear_word(st_i);
               st_o.mode = MODE_DEFAULT;
               win_o     = '0;
               used      = 1'b1;
            end else begin
               st_o.wlen = len_add(st_i.wlen, 2'd1);
            end
         end
         MODE_DEFAULT: begin
            unique case (cls)
               CLS_SPACE: begin
                  tok0  = flush_tok;
                  st_o  = clear_word(st_i);
                  win_o = '0;
               end
               CLS_SLASH: begin
                  tok0  = flush_tok;
                  st_o  = clear_word(st_i);
                  win_o = '0;
                  if (hp && (pk == CH_STAR || pk == CH_SLASH)) begin
                     st_o.mode   = (pk == CH_STAR) ? MODE_BLOCK : MODE_LINE;
                     st_o.wstart = pos;
                     st_o.wlen   = LEN_W'(2);
                     used        = 1'b1;
                  end else if (hp && pk == CH_EQ) begin
                     tok1 = '{1'b1, T_DIV_ASSIGN, pos, LEN_W'(2)};
                     used = 1'b1;
                  end else begin
                     tok1 = '{1'b1, T_DIV, pos, LEN_W'(1)};
                  end
               end
               CLS_QUOTE: begin
                  tok0           = flush_tok;
                  st_o           = clear_word(st_i);
                  win_o          = '0;
                  st_o.mode      = MODE_STRING;
                  st_o.quote_dbl = (c == CH_DQUOTE);
                  st_o.wstart    = pos;
                  st_o.wlen      = LEN_W'(1);
               end
               CLS_BSL: begin
                  if (hp && pk == CH_N) begin
                     tok0  = flush_tok;
                     st_o  = clear_word(st_i);
                     win_o = '0;
                     tok1  = '{1'b1, T_NEW_LINE, pos, LEN_W'(2)};
                     used  = 1'b1;
                  end
               end
               CLS_OP: begin
                  tok0  = flush_tok;
                  st_o  = clear_word(st_i);
                  win_o = '0;
                  tok1  = '{1'b1, op.code, pos, op.pair ? LEN_W'(2) : LEN_W'(1)};
                  used  = op.pair;
               end
               default: begin
                  if (st_i.wlen == '0) begin
                     st_o.wstart      = pos;
                     st_o.digit_first = (c >= CH_0) && (c <= CH_9);
                     win_base         = '0;
                  end
                  win_o = win_base;
                  for (int b = 0; b < KEYWORD_BYTES; b++) begin
                     if (st_i.wlen == LEN_W'(b)) begin
                        win_o[8*b +: 8] = c;
                     end
                  end
                  st_o.wlen = len_add(st_i.wlen, 2'd1);
               end
            endcase
         end
      endcase
   end

endmodule

// File: src/cst_step.sv
// Tokenizer state registers and the per-request step: held byte with lookahead,
// end-of-text drain and final word flush. Depends on cst_pkg, cst_lex and cst_kw.
module cst_step import cst_pkg::*; #(
   parameter int KEYWORD_BYTES = KEYWORD_BYTES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  req_type                  req,
   output tok_type [SLOTS-1:0]      slot
);

   localparam int WIN_W = 8 * KEYWORD_BYTES;

   lex_state_type    st_ff, st_in;
   logic [WIN_W-1:0] win_ff, win_in;
   logic [7:0]       pchar_ff, pchar_in;
   logic             pvld_ff, pvld_in;
   logic [POS_W-1:0] pos_ff, pos_in;

   lex_state_type    st_a, st_1, st_b, st_2;
   logic [WIN_W-1:0] win_a, win_1, win_b, win_2;
   tok_type          a0, a1, b0, b1;
   logic             used_a;
   logic [7:0]       pc_1;
   logic             pv_1;
   logic [POS_W-1:0] pos_1;
   logic             act_b;
   logic [5:0]       fin_code;

   cst_lex #(.KEYWORD_BYTES(KEYWORD_BYTES)) u_lex_look (
      .st_i (st_ff),
      .win_i(win_ff),
      .c    (pchar_ff),
      .hp   (1'b1),
      .pk   (req.char_code),
      .pos  (pos_ff),
      .st_o (st_a),
      .win_o(win_a),
      .tok0 (a0),
      .tok1 (a1),
      .used (used_a)
   );

   always_comb begin
      if (pvld_ff) begin
         st_1  = st_a;
         win_1 = win_a;
         if (used_a) begin
            pv_1  = 1'b0;
            pc_1  = pchar_ff;
            pos_1 = pos_inc(pos_inc(pos_ff));
         end else begin
            pv_1  = 1'b1;
            pc_1  = req.char_code;
            pos_1 = pos_inc(pos_ff);
         end
      end else begin
         st_1  = st_ff;
         win_1 = win_ff;
         pv_1  = 1'b1;
         pc_1  = req.char_code;
         pos_1 = pos_ff;
      end
   end

   cst_lex #(.KEYWORD_BYTES(KEYWORD_BYTES)) u_lex_last (
      .st_i (st_1),
      .win_i(win_1),
      .c    (pc_1),
      .hp   (1'b0),
      .pk   (8'h00),
      .pos  (pos_1),
      .st_o (st_b),
      .win_o(win_b),
      .tok0 (b0),
      .tok1 (b1),
      .used ()
   );

   assign act_b = req.end_of_text && pv_1;
   assign st_2  = act_b ? st_b : st_1;
   assign win_2 = act_b ? win_b : win_1;

   cst_kw #(.KEYWORD_BYTES(KEYWORD_BYTES)) u_kw_final (
      .wlen        (st_2.wlen),
      .win         (win_2),
      .digit_first (st_2.digit_first),
      .code        (fin_code)
   );

   always_comb begin
      slot[0]     = a0;
      slot[0].vld = a0.vld && pvld_ff;
      slot[1]     = a1;
      slot[1].vld = a1.vld && pvld_ff;
      slot[2]     = b0;
      slot[2].vld = b0.vld && act_b;
      slot[3]     = b1;
      slot[3].vld = b1.vld && act_b;
      slot[4]     = '{req.end_of_text && st_2.wlen != '0,
                      (st_2.mode == MODE_DEFAULT) ? fin_code : T_IDENTIFIER,
                      st_2.wstart, st_2.wlen};
   end

   always_comb begin
      if (req.end_of_text) begin
         st_in    = '0;
         win_in   = '0;
         pchar_in = '0;
         pvld_in  = 1'b0;
         pos_in   = '0;
      end else begin
         st_in    = st_1;
         win_in   = win_1;
         pchar_in = pc_1;
         pvld_in  = pv_1;
         pos_in   = pos_1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= '0;
         win_ff   <= '0;
         pchar_ff <= '0;
         pvld_ff  <= 1'b0;
         pos_ff   <= '0;
      end else if (advance) begin
         st_ff    <= st_in;
         win_ff   <= win_in;
         pchar_ff <= pchar_in;
         pvld_ff  <= pvld_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

// File: src/cst_tok_fifo.sv
// Token queue: packs up to four tokens of one step in order, marks the last, and drains
// one a cycle unless stalled. Depends on cst_pkg.
module cst_tok_fifo import cst_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tok_type [SLOTS-1:0] slot,
   output logic                room,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data
);

   localparam int QAW   = $clog2(Q_DEPTH);
   localparam int OFS_W = $clog2(SLOTS + 1);

   rsp_type          ent_ff [Q_DEPTH];
   logic [QAW-1:0]   head_ff, head_in;
   logic [QAW-1:0]   tail_ff, tail_in;
   logic [QAW:0]     cnt_ff, cnt_in;

   logic [OFS_W-1:0] ofs [SLOTS];
   logic [OFS_W-1:0] n_all, n_push, last_idx;
   logic             pop;

   always_comb begin
      ofs[0] = '0;
      for (int i = 1; i < SLOTS; i++) begin
         ofs[i] = ofs[i-1] + OFS_W'(slot[i-1].vld);
      end
      n_all = ofs[SLOTS-1] + OFS_W'(slot[SLOTS-1].vld);
   end

   assign n_push   = !push ? '0 : (n_all > OFS_W'(MAX_RES)) ? OFS_W'(MAX_RES) : n_all;
   assign last_idx = n_push - 1'b1;

   assign room      = cnt_ff <= (QAW+1)'(Q_DEPTH - MAX_RES);
   assign rsp_valid = cnt_ff != '0;
   assign rsp_data  = ent_ff[head_ff];
   assign pop       = rsp_valid && !rsp_stall;

   assign head_in = head_ff + QAW'(pop);
   assign tail_in = tail_ff + QAW'(n_push);
   assign cnt_in  = cnt_ff + (QAW+1)'(n_push) - (QAW+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOTS; i++) begin
         if (push && slot[i].vld && ofs[i] < OFS_W'(MAX_RES)) begin
            ent_ff[tail_ff + QAW'(ofs[i])] <= '{slot[i].code, slot[i].start, slot[i].len,
                                                 ofs[i] == last_idx};
         end
      end
   end

endmodule

// File: src/char_stream_tokenizer.sv
// Top level of the streaming tokenizer: request register, step logic and token queue.
// Depends on cst_pkg, cst_step and cst_tok_fifo.
//
// Usage:
//   Requests carry one text byte and an end-of-text flag on req_valid/req_stall;
//   tokens (type, start, length, last_in_run) leave on rsp_valid/rsp_stall.
//   A byte is held back until the next byte arrives as lookahead, so its tokens
//   appear with the following request; the end-of-text request drains everything
//   and returns the tokenizer to the start of a new text at position 0.
//   Request path: a request is registered in the request register on acceptance
//   and processed by the step logic from there; its tokens are written into the
//   token queue, whose head entry is offered on rsp_valid/rsp_stall.
//   Throughput: one request per cycle while the token queue has room for four more
//   tokens; each request yields zero to four tokens and the queue drains one token
//   a cycle unless stalled, so a request that yields several tokens holds back later ones.
//   Reset (synchronous, active high) empties the queue, drops any held byte and
//   clears the position count. When the receiver stalls, the head token holds and
//   requests stall as soon as the eight-entry queue cannot take four more tokens.
module char_stream_tokenizer import cst_pkg::*; #(
   parameter int KEYWORD_BYTES = KEYWORD_BYTES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   req_type             req_ff, req_in;
   logic                req_vld_ff, req_vld_in;
   logic                room;
   logic                advance;
   tok_type [SLOTS-1:0] slot;

   assign advance    = req_vld_ff && room;
   assign req_stall  = req_vld_ff && !room;
   assign req_vld_in = req_stall ? req_vld_ff : req_valid;
   assign req_in     = (req_valid && !req_stall) ? req_data : req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= req_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
   end

   cst_step #(.KEYWORD_BYTES(KEYWORD_BYTES)) u_step (
      .clock  (clock),
      .reset  (reset),
      .advance(advance),
      .req    (req_ff),
      .slot   (slot)
   );

   cst_tok_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (advance),
      .slot     (slot),
      .room     (room),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule

// File: src/cst_checker.sv
// Port-level checks on the tokenizer's token channel, bound to the top level.
// Depends on cst_pkg and char_stream_tokenizer.
module cst_checker import cst_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("token offered right after reset");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled token changed or dropped");

   a_type_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.token_code <= T_NEW_LINE)
      else $error("token type out of range");

   a_newline_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.token_code == T_NEW_LINE |-> rsp_data.token_length == 16'd2)
      else $error("newline token with wrong length");

endmodule

bind char_stream_tokenizer cst_checker u_cst_checker (.*);
